// ----- hw/rtl/ect_pkg.sv -----
// package: shared types, sizes and result codes of the expression tokenizer
`timescale 1ns / 1ps
`default_nettype none

package ect_pkg;

    localparam int MAX_WORD_LEN = 4;
    localparam int WORD_LEN_W   = $clog2(MAX_WORD_LEN + 1);
    localparam int WORD_IDX_W   = $clog2(MAX_WORD_LEN);

    localparam int RESULTS_MAX = 3;
    localparam int COUNT_W     = $clog2(RESULTS_MAX + 1);
    localparam int SLOT_W      = $clog2(RESULTS_MAX);

    localparam logic [2:0] KIND_NUMBER   = 3'd0;
    localparam logic [2:0] KIND_OPERATOR = 3'd1;
    localparam logic [2:0] KIND_FUNCTION = 3'd2;
    localparam logic [2:0] KIND_ERROR    = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;

    localparam logic [7:0] FUNC_CEIL = 8'd0;
    localparam logic [7:0] FUNC_SQRT = 8'd1;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       token_start;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0]            count;
        result_t [RESULTS_MAX-1:0]     res;
    } bundle_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ect_text_if.sv -----
// interface: text byte channel
`timescale 1ns / 1ps
`default_nettype none

interface ect_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       final_char;

    modport source (output valid, output ch, output final_char, input ready);
    modport sink (input valid, input ch, input final_char, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ect_token_if.sv -----
// interface: token result channel
`timescale 1ns / 1ps
`default_nettype none

interface ect_token_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic       token_start;
    logic       run_last;

    modport source (output valid, output kind, output value, output token_start,
                    output run_last, input ready);
    modport sink (input valid, input kind, input value, input token_start,
                  input run_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/expression_char_tokenizer.sv -----
// top level: streaming tokenizer for arithmetic expression text
//
// text carries one byte per transaction, with final_char on the last byte of
// an expression. tokens carries one result per transaction: kind, value,
// token_start and run_last, which marks the last result caused by one byte.
// a byte is taken every cycle while the two-bundle queue has room; it
// causes zero to three results, which come out one per cycle while tokens is ready.
// the results of a byte are registered in the queue, so its first result is
// offered the cycle after the byte is accepted when the queue was empty.
// throughput: one byte per cycle while each byte causes at most one result
// and tokens is ready; a byte with several results holds the token port until
// all of them are sent, since the back end has a single-result output port.
// when tokens stalls, the queue fills and text.ready drops after two
// bundles wait; nothing is lost or repeated.
// reset empties the queue and returns the lexer to the idle state between
// tokens with no word held.
`timescale 1ns / 1ps
`default_nettype none

module expression_char_tokenizer (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ect_text_if.sink     text,
    ect_token_if.source  tokens
);

    ect_pkg::bundle_t wr_bundle;
    ect_pkg::bundle_t head;
    logic             push;
    logic             pop;
    logic             full;
    logic             head_valid;

    ect_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .full   (full),
        .bundle (wr_bundle),
        .push   (push)
    );

    ect_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_bundle  (wr_bundle),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    ect_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .tokens     (tokens)
    );

    // the final byte always causes at least the end result
    a_final_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid && text.ready && text.final_char |-> push)
        else $error("final byte produced no bundle");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid && tokens.kind == ect_pkg::KIND_END |-> tokens.run_last)
        else $error("end result not last of its byte");

    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        full && pop |=> !full)
        else $error("queue stayed full after a pop");

    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> !tokens.valid && !pop)
        else $error("token offered from an empty queue");

endmodule

`default_nettype wire

// ----- hw/rtl/ect_front.sv -----
// front end: classifies each text byte and builds the bundle of results it causes
`timescale 1ns / 1ps
`default_nettype none

module ect_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    ect_text_if.sink             text,
    input  wire logic            full,
    output ect_pkg::bundle_t     bundle,
    output logic                 push
);

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_NUMBER = 2'd1;
    localparam logic [1:0] MODE_WORD   = 2'd2;
    localparam logic [1:0] MODE_DROP   = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;

    localparam logic [31:0] WORD_CEIL = 32'h6365696c;
    localparam logic [31:0] WORD_SQRT = 32'h73717274;

    typedef logic [7:0] letters_t [ect_pkg::MAX_WORD_LEN];

    typedef struct packed {
        logic                emit;
        ect_pkg::result_t    res;
        logic [1:0]          mode;
        logic                word;
    } start_t;

    typedef struct packed {
        ect_pkg::result_t    res;
        logic [1:0]          mode;
    } finish_t;

    logic [1:0]                   mode_reg, mode_next;
    logic [ect_pkg::WORD_LEN_W-1:0] len_reg, len_next;
    letters_t                     letters_reg, letters_next;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH
            || c == CH_LPAR || c == CH_RPAR;
    endfunction

    function automatic ect_pkg::result_t mk(input logic [2:0] kind, input logic [7:0] value,
                                            input logic start);
        ect_pkg::result_t r;
        r.kind        = kind;
        r.value       = value;
        r.token_start = start;
        return r;
    endfunction

    function automatic start_t start_token(input logic [7:0] c);
        start_t s;
        s.emit = 1'b0;
        s.res  = mk(ect_pkg::KIND_ERROR, c, 1'b1);
        s.mode = MODE_IDLE;
        s.word = 1'b0;
        if (c == CH_SPACE)
        begin
            s.emit = 1'b0;
        end
        else if (is_digit(c))
        begin
            s.emit = 1'b1;
            s.res  = mk(ect_pkg::KIND_NUMBER, c, 1'b1);
            s.mode = MODE_NUMBER;
        end
        else if (is_op(c))
        begin
            s.emit = 1'b1;
            s.res  = mk(ect_pkg::KIND_OPERATOR, c, 1'b1);
        end
        else if (is_letter(c))
        begin
            s.word = 1'b1;
            s.mode = MODE_WORD;
        end
        else
        begin
            s.emit = 1'b1;
            s.mode = MODE_DROP;
        end
        return s;
    endfunction

    function automatic finish_t finish_word(input letters_t lv,
                                            input logic [ect_pkg::WORD_LEN_W-1:0] lenv);
        finish_t f;
        logic    len4;
        len4 = lenv == ect_pkg::WORD_LEN_W'(4);
        if (len4 && {lv[0], lv[1], lv[2], lv[3]} == WORD_CEIL)
        begin
            f.res  = mk(ect_pkg::KIND_FUNCTION, ect_pkg::FUNC_CEIL, 1'b1);
            f.mode = MODE_IDLE;
        end
        else if (len4 && {lv[0], lv[1], lv[2], lv[3]} == WORD_SQRT)
        begin
            f.res  = mk(ect_pkg::KIND_FUNCTION, ect_pkg::FUNC_SQRT, 1'b1);
            f.mode = MODE_IDLE;
        end
        else
        begin
            f.res  = mk(ect_pkg::KIND_ERROR, lv[0], 1'b1);
            f.mode = MODE_DROP;
        end
        return f;
    endfunction

    logic                                accept;
    logic [ect_pkg::COUNT_W-1:0]         n;
    ect_pkg::result_t [ect_pkg::RESULTS_MAX-1:0] res;
    logic                                do_start;
    start_t                              st;
    finish_t                             fw;

    assign text.ready = !full;
    assign accept     = text.valid && text.ready;

    always_comb
    begin
        letters_next = letters_reg;
        len_next     = len_reg;
        mode_next    = mode_reg;
        n            = '0;
        res          = '0;
        do_start     = 1'b0;
        st           = start_token(text.ch);
        fw           = '0;

        unique case (mode_reg)
            MODE_NUMBER:
            begin
                if (is_digit(text.ch) || text.ch == CH_DOT)
                begin
                    res[n[ect_pkg::SLOT_W-1:0]] = mk(ect_pkg::KIND_NUMBER, text.ch, 1'b0);
                    n = n + ect_pkg::COUNT_W'(1);
                end
                else
                begin
                    mode_next = MODE_IDLE;
                    do_start  = 1'b1;
                end
            end
            MODE_WORD:
            begin
                if (is_letter(text.ch))
                begin
                    if (len_next < ect_pkg::WORD_LEN_W'(ect_pkg::MAX_WORD_LEN))
                    begin
                        letters_next[len_next[ect_pkg::WORD_IDX_W-1:0]] = text.ch;
                        len_next = len_next + ect_pkg::WORD_LEN_W'(1);
                    end
                    else
                    begin
                        res[n[ect_pkg::SLOT_W-1:0]] =
                            mk(ect_pkg::KIND_ERROR, letters_next[0], 1'b1);
                        n         = n + ect_pkg::COUNT_W'(1);
                        mode_next = MODE_DROP;
                        len_next  = '0;
                    end
                end
                else
                begin
                    fw = finish_word(letters_next, len_next);
                    res[n[ect_pkg::SLOT_W-1:0]] = fw.res;
                    n         = n + ect_pkg::COUNT_W'(1);
                    mode_next = fw.mode;
                    len_next  = '0;
                    do_start  = fw.mode == MODE_IDLE;
                end
            end
            MODE_IDLE:
            begin
                do_start = 1'b1;
            end
            MODE_DROP:
            begin
                do_start = 1'b0;
            end
            default:
            begin
                do_start = 1'b0;
            end
        endcase

        if (do_start)
        begin
            if (st.emit)
            begin
                res[n[ect_pkg::SLOT_W-1:0]] = st.res;
                n = n + ect_pkg::COUNT_W'(1);
            end
            if (st.word)
            begin
                letters_next[0] = text.ch;
                len_next        = ect_pkg::WORD_LEN_W'(1);
            end
            mode_next = st.mode;
        end

        if (text.final_char)
        begin
            if (mode_next == MODE_WORD)
            begin
                fw = finish_word(letters_next, len_next);
                res[n[ect_pkg::SLOT_W-1:0]] = fw.res;
                n = n + ect_pkg::COUNT_W'(1);
            end
            res[n[ect_pkg::SLOT_W-1:0]] = mk(ect_pkg::KIND_END, 8'd0, 1'b0);
            n         = n + ect_pkg::COUNT_W'(1);
            mode_next = MODE_IDLE;
            len_next  = '0;
        end
    end

    assign bundle = '{count: n, res: res};
    assign push   = accept && (n != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            len_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            letters_reg <= letters_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ect_queue.sv -----
// two-entry queue of result bundles between front and back
`timescale 1ns / 1ps
`default_nettype none

module ect_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ect_pkg::bundle_t  wr_bundle,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output ect_pkg::bundle_t       head
);

    ect_pkg::bundle_t mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_bundle;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ect_back.sv -----
// back end: sends the results of each bundle one transaction at a time
`timescale 1ns / 1ps
`default_nettype none

module ect_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire ect_pkg::bundle_t  head,
    output logic                   pop,
    ect_token_if.source            tokens
);

    logic [ect_pkg::SLOT_W-1:0] idx_reg, idx_next;
    logic                       last;
    logic                       accept;
    ect_pkg::result_t           cur;

    assign cur    = head.res[idx_reg];
    assign last   = ect_pkg::COUNT_W'(idx_reg) == head.count - ect_pkg::COUNT_W'(1);
    assign accept = tokens.valid && tokens.ready;
    assign pop    = accept && last;

    assign tokens.valid       = head_valid;
    assign tokens.kind        = cur.kind;
    assign tokens.value       = cur.value;
    assign tokens.token_start = cur.token_start;
    assign tokens.run_last    = last;

    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            idx_next = last ? '0 : idx_reg + ect_pkg::SLOT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// testbench: expression tokenizer, directed and random text checked against a lexer predictor or typed tokens
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       token_start;
        logic       run_last;
    } token_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic [1:0] n_typed;
        token_t     t0;
        token_t     t1;
    } text_row_t;

    typedef enum logic [1:0] {LEX_IDLE, LEX_NUMBER, LEX_WORD, LEX_DROP} lex_mode_t;

    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_DOT   = ".";

    logic clk;
    logic rst_n;

    ect_text_if  text_ch ();
    ect_token_if token_ch ();

    expression_char_tokenizer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .tokens (token_ch)
    );

    lex_mode_t  lex_mode = LEX_IDLE;
    logic [7:0] word_buf [ect_pkg::MAX_WORD_LEN];
    int         word_len = 0;
    token_t     lex_out [ect_pkg::RESULTS_MAX];
    int         lex_n;

    token_t     token_expect_q [$];
    text_row_t  directed_rows [$];
    int         fail_count = 0;
    int         counted_bytes = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         long_hold_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic token_t mk_tok(input logic [2:0] k, input logic [7:0] v,
                                      input logic s, input logic l);
        token_t t;
        t.kind        = k;
        t.value       = v;
        t.token_start = s;
        t.run_last    = l;
        return t;
    endfunction

    function automatic text_row_t row(input logic [7:0] c, input logic f,
                                      input logic [1:0] n, input token_t a, input token_t b);
        text_row_t r;
        r.ch      = c;
        r.fin     = f;
        r.n_typed = n;
        r.t0      = a;
        r.t1      = b;
        return r;
    endfunction

    function automatic void add_row(input text_row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic void add_expect(input token_t t);
        token_expect_q.insert(token_expect_q.size(), t);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_op(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "(" || c == ")";
    endfunction

    function automatic void lex_emit(input logic [2:0] k, input logic [7:0] v, input logic s);
        lex_out[lex_n] = mk_tok(k, v, s, 1'b0);
        lex_n++;
    endfunction

    function automatic void close_word();
        logic [31:0] w;
        w = {word_buf[0], word_buf[1], word_buf[2], word_buf[3]};
        if (word_len == 4 && w == "ceil")
        begin
            lex_emit(ect_pkg::KIND_FUNCTION, ect_pkg::FUNC_CEIL, 1'b1);
            lex_mode = LEX_IDLE;
        end
        else if (word_len == 4 && w == "sqrt")
        begin
            lex_emit(ect_pkg::KIND_FUNCTION, ect_pkg::FUNC_SQRT, 1'b1);
            lex_mode = LEX_IDLE;
        end
        else
        begin
            lex_emit(ect_pkg::KIND_ERROR, word_buf[0], 1'b1);
            lex_mode = LEX_DROP;
        end
        word_len = 0;
    endfunction

    function automatic void open_token(input logic [7:0] c);
        if (c == CH_SPACE)
            return;
        if (is_digit(c))
        begin
            lex_emit(ect_pkg::KIND_NUMBER, c, 1'b1);
            lex_mode = LEX_NUMBER;
        end
        else if (is_op(c))
            lex_emit(ect_pkg::KIND_OPERATOR, c, 1'b1);
        else if (is_letter(c))
        begin
            word_buf[0] = c;
            word_len    = 1;
            lex_mode    = LEX_WORD;
        end
        else
        begin
            lex_emit(ect_pkg::KIND_ERROR, c, 1'b1);
            lex_mode = LEX_DROP;
        end
    endfunction

    function automatic void lex_byte(input logic [7:0] c, input logic f);
        lex_n = 0;
        case (lex_mode)
            LEX_NUMBER:
                if (is_digit(c) || c == CH_DOT)
                    lex_emit(ect_pkg::KIND_NUMBER, c, 1'b0);
                else
                begin
                    lex_mode = LEX_IDLE;
                    open_token(c);
                end
            LEX_WORD:
                if (is_letter(c))
                begin
                    if (word_len < ect_pkg::MAX_WORD_LEN)
                    begin
                        word_buf[word_len] = c;
                        word_len++;
                    end
                    else
                    begin
                        lex_emit(ect_pkg::KIND_ERROR, word_buf[0], 1'b1);
                        lex_mode = LEX_DROP;
                        word_len = 0;
                    end
                end
                else
                begin
                    close_word();
                    if (lex_mode == LEX_IDLE)
                        open_token(c);
                end
            LEX_IDLE:
                open_token(c);
            default:
                ;
        endcase
        if (f)
        begin
            if (lex_mode == LEX_WORD)
                close_word();
            lex_emit(ect_pkg::KIND_END, 8'd0, 1'b0);
            lex_mode = LEX_IDLE;
            word_len = 0;
        end
        if (lex_n > 0)
            lex_out[lex_n-1].run_last = 1'b1;
    endfunction

    task automatic send_byte(input text_row_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            text_ch.valid      <= 1'b0;
            text_ch.ch         <= 8'($urandom);
            text_ch.final_char <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        text_ch.valid      <= 1'b1;
        text_ch.ch         <= r.ch;
        text_ch.final_char <= r.fin;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        counted_bytes++;
        lex_byte(r.ch, r.fin);
        if (r.n_typed != 0)
        begin
            add_expect(r.t0);
            if (r.n_typed > 1)
                add_expect(r.t1);
        end
        else
            for (int i = 0; i < lex_n; i++)
                add_expect(lex_out[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        int k;
        k = $urandom_range(0, 51);
        return (k < 26) ? 8'("A" + k) : 8'("a" + k - 26);
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 5))
            0: return "+";
            1: return "-";
            2: return "*";
            3: return "/";
            4: return "(";
            default: return ")";
        endcase
    endfunction

    // mostly well-formed expressions, some noise bytes and bad words
    task automatic send_random_text();
        logic [7:0] bytes [$];
        text_row_t  r;
        int         n_tok;
        int         pick;
        int         len;
        n_tok = $urandom_range(1, 6);
        for (int t = 0; t < n_tok; t++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                bytes.insert(bytes.size(), 8'("0" + $urandom_range(0, 9)));
                len = $urandom_range(0, 3);
                for (int k = 0; k < len; k++)
                    bytes.insert(bytes.size(), ($urandom_range(0, 4) == 0) ? CH_DOT
                                 : 8'("0" + $urandom_range(0, 9)));
            end
            else if (pick < 60)
                bytes.insert(bytes.size(), rand_op());
            else if (pick < 72)
            begin
                if ($urandom_range(0, 1))
                begin
                    bytes.insert(bytes.size(), "c"); bytes.insert(bytes.size(), "e");
                    bytes.insert(bytes.size(), "i"); bytes.insert(bytes.size(), "l");
                end
                else
                begin
                    bytes.insert(bytes.size(), "s"); bytes.insert(bytes.size(), "q");
                    bytes.insert(bytes.size(), "r"); bytes.insert(bytes.size(), "t");
                end
            end
            else if (pick < 80)
                bytes.insert(bytes.size(), CH_SPACE);
            else if (pick < 90)
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    bytes.insert(bytes.size(), rand_letter());
            end
            else
                bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) < 40)
                bytes.insert(bytes.size(), CH_SPACE);
        end
        foreach (bytes[i])
        begin
            r = row(bytes[i], i == bytes.size() - 1, 2'd0, '0, '0);
            send_byte(r);
        end
    endtask

    task automatic check_token();
        token_t want;
        if (token_expect_q.size() == 0)
        begin
            $error("unexpected transaction: kind %0d value %0d", token_ch.kind, token_ch.value);
            fail_count++;
            return;
        end
        want = token_expect_q.pop_front();
        if (token_ch.kind !== want.kind)
        begin
            $error("kind: expected %0d, actual %0d", want.kind, token_ch.kind);
            fail_count++;
        end
        if (token_ch.value !== want.value)
        begin
            $error("value: expected %0d, actual %0d", want.value, token_ch.value);
            fail_count++;
        end
        if (token_ch.token_start !== want.token_start)
        begin
            $error("token_start: expected %0d, actual %0d", want.token_start,
                   token_ch.token_start);
            fail_count++;
        end
        if (token_ch.run_last !== want.run_last)
        begin
            $error("run_last: expected %0d, actual %0d", want.run_last, token_ch.run_last);
            fail_count++;
        end
    endtask

    initial
    begin
        token_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && token_ch.valid && token_ch.ready)
                check_token();
            if (long_hold_left > 0)
            begin
                token_ch.ready <= 1'b0;
                long_hold_left--;
            end
            else
                token_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int target;
        rst_n              <= 1'b0;
        text_ch.valid      <= 1'b0;
        text_ch.ch         <= 8'd0;
        text_ch.final_char <= 1'b0;

        // numbers, every operator, good words, leading dot, non-ascii, long word
        add_row(row("0", 1'b0, 2'd1,
                    mk_tok(ect_pkg::KIND_NUMBER, "0", 1'b1, 1'b1), '0));
        add_row(row("9", 1'b0, 2'd0, '0, '0));
        add_row(row(".", 1'b0, 2'd0, '0, '0));
        add_row(row(" ", 1'b0, 2'd0, '0, '0));
        add_row(row("+", 1'b0, 2'd1,
                    mk_tok(ect_pkg::KIND_OPERATOR, "+", 1'b1, 1'b1), '0));
        add_row(row("-", 1'b0, 2'd0, '0, '0));
        add_row(row("*", 1'b0, 2'd0, '0, '0));
        add_row(row("/", 1'b0, 2'd0, '0, '0));
        add_row(row("(", 1'b0, 2'd0, '0, '0));
        add_row(row(")", 1'b0, 2'd0, '0, '0));
        add_row(row("c", 1'b0, 2'd0, '0, '0));
        add_row(row("e", 1'b0, 2'd0, '0, '0));
        add_row(row("i", 1'b0, 2'd0, '0, '0));
        add_row(row("l", 1'b0, 2'd0, '0, '0));
        add_row(row("(", 1'b0, 2'd0, '0, '0));
        add_row(row("s", 1'b0, 2'd0, '0, '0));
        add_row(row("q", 1'b0, 2'd0, '0, '0));
        add_row(row("r", 1'b0, 2'd0, '0, '0));
        add_row(row("t", 1'b1, 2'd0, '0, '0));
        add_row(row(".", 1'b1, 2'd2,
                    mk_tok(ect_pkg::KIND_ERROR, ".", 1'b1, 1'b0),
                    mk_tok(ect_pkg::KIND_END, 8'd0, 1'b0, 1'b1)));
        add_row(row(8'hFF, 1'b1, 2'd2,
                    mk_tok(ect_pkg::KIND_ERROR, 8'hFF, 1'b1, 1'b0),
                    mk_tok(ect_pkg::KIND_END, 8'd0, 1'b0, 1'b1)));
        add_row(row("a", 1'b0, 2'd0, '0, '0));
        add_row(row("B", 1'b0, 2'd0, '0, '0));
        add_row(row("c", 1'b0, 2'd0, '0, '0));
        add_row(row("d", 1'b0, 2'd0, '0, '0));
        add_row(row("e", 1'b1, 2'd0, '0, '0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i]);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  long_hold_left = 64; end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            target = counted_bytes + 50;
            while (counted_bytes < target)
                send_random_text();
        end
        text_ch.valid <= 1'b0;

        while (token_expect_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
